// File: src/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
// No dependencies; every other file of the block imports this package.
package rbst_pkg;

  localparam int unsigned W          = 32;
  localparam int unsigned AXES       = 3;
  // An item carries three axes, so at most three lanes do work.
  localparam int unsigned ITEM_AXES  = 3;
  localparam int unsigned LANES      = (AXES < ITEM_AXES) ? AXES : ITEM_AXES;
  localparam int unsigned FRAC       = 16;
  localparam int unsigned PROD_W     = 2 * W + 1;
  localparam int unsigned SHIFT_W    = PROD_W - FRAC;
  // 2^32 has 33 bits, so the reciprocal takes one quotient bit per step.
  localparam int unsigned RECIP_STEPS = W + 1;
  localparam int unsigned RCNT_W     = $clog2(RECIP_STEPS);
  localparam int unsigned IN_DATA_W  = 8 * W;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [W-1:0] S32_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] S32_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } rbst_req_e;

  typedef struct packed {
    logic ld;   // capture origin and start the reciprocal
    logic tst;  // capture box corners
  } rbst_lane_ctrl_t;

endpackage

// File: src/ray_box_slab_test_top.sv
// Channel  | dir | beats carry
// s_axis   | in  | tuser: req_type; tdata: first_xyz, second_xyz, t_start, t_end
// m_axis   | out | tdata: hit, padded to one byte
//
// A box test keeps the input busy through the multiply, saturate and merge states; its
// operands pass the corner, product and near/far registers before the output register.
// A ray load lasts until the 33-step bit-serial reciprocal in each lane is done.
// One item is in work at a time; the input is ready again as soon as it finishes,
// even while the last result still waits in the output register.
// A stalled output holds the merge stage until the output register frees up.
// Reset clears the stored ray to zero, so a test before any load misses.
// Top level of the slab test: lanes, interval merge and control. Depends on rbst_pkg,
// rbst_lane.
module ray_box_slab_test_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // From bit 0: first_x, first_y, first_z, second_x, second_y, second_z, t_start, t_end.
  input  logic [rbst_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // Bit 0: req_type.
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Bit 0: hit; upper bits zero.
  output logic [rbst_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import rbst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RECIP = 5'b00010,
    S_MUL   = 5'b00100,
    S_SAT   = 5'b01000,
    S_MERGE = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic            accept;
  rbst_lane_ctrl_t lane_ctrl;
  logic [LANES-1:0] lane_done;
  logic [W-1:0]    t_near [LANES];
  logic [W-1:0]    t_far  [LANES];
  logic [W-1:0]    tmin_q, tmax_q;
  logic            out_valid_q, out_valid_d;
  logic            out_hit_q, out_hit_d;
  logic            hit;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign lane_ctrl.ld    = accept & (s_axis_tuser_i == REQ_LOAD);
  assign lane_ctrl.tst   = accept & (s_axis_tuser_i == REQ_TEST);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    rbst_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .origin_i (s_axis_tdata_i[W*i +: W]),
      .dir_i    (s_axis_tdata_i[W*(ITEM_AXES+i) +: W]),
      .cmin_i   (s_axis_tdata_i[W*i +: W]),
      .cmax_i   (s_axis_tdata_i[W*(ITEM_AXES+i) +: W]),
      .done_o   (lane_done[i]),
      .t_near_o (t_near[i]),
      .t_far_o  (t_far[i])
    );
  end

  // Narrowing past an empty interval never reopens it, so only the final
  // max and min need comparing.
  always_comb begin
    logic [W-1:0] lo, hi;
    lo = tmin_q;
    hi = tmax_q;
    for (int i = 0; i < LANES; i++) begin
      if ($signed(t_near[i]) > $signed(lo)) begin
        lo = t_near[i];
      end
      if ($signed(t_far[i]) < $signed(hi)) begin
        hi = t_far[i];
      end
    end
    hit = ($signed(lo) < $signed(hi));
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (lane_ctrl.ld) begin
          state_d = S_RECIP;
        end else if (lane_ctrl.tst) begin
          state_d = S_MUL;
        end
      end
      S_RECIP: begin
        if (&lane_done) begin
          state_d = S_IDLE;
        end
      end
      S_MUL:   state_d = S_SAT;
      S_SAT:   state_d = S_MERGE;
      S_MERGE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tmin_q      <= '0;
      tmax_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (lane_ctrl.ld) begin
        tmin_q <= s_axis_tdata_i[W*(2*ITEM_AXES) +: W];
        tmax_q <= s_axis_tdata_i[W*(2*ITEM_AXES+1) +: W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q <= out_hit_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-1){1'b0}}, out_hit_q};

endmodule

// File: src/rbst_recip.sv
// Sequential reciprocal unit: 2^32 / d truncated toward zero, saturated to 32 bits.
// One restoring division step per cycle. Depends on rbst_pkg.
module rbst_recip (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [rbst_pkg::W-1:0] d_i,
  output logic                 done_o,
  output logic [rbst_pkg::W-1:0] recip_o
);
  import rbst_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [RCNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W:0]        quo_q, quo_d;
  logic [W-1:0]      mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [W:0]        shifted;
  logic [W+1:0]      trial;
  logic              ge;

  // The dividend is a single one followed by W zeros, fed from the top.
  assign shifted = {rem_q, (cnt_q == '0)};
  assign trial   = {1'b0, shifted} - {2'b00, mag_q};
  assign ge      = ~trial[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = '0;
      neg_d  = d_i[W-1];
      mag_d  = d_i[W-1] ? (~d_i + {{(W-1){1'b0}}, 1'b1}) : d_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-1:0], ge};
      cnt_d = cnt_q + {{(RCNT_W-1){1'b0}}, 1'b1};
      if (cnt_q == RCNT_W'(RECIP_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      recip_o = (quo_q[W] | (quo_q[W-1] & (|quo_q[W-2:0]))) ? S32_MIN
                                                             : (~quo_q[W-1:0] + 1'b1);
    end else begin
      recip_o = (quo_q[W] | quo_q[W-1]) ? S32_MAX : quo_q[W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: src/rbst_lane.sv
// One axis lane: stored origin and reciprocal, two slab distances per box.
// Multiply stage, then floor shift, saturation and swap. Depends on rbst_pkg, rbst_recip.
module rbst_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rbst_pkg::rbst_lane_ctrl_t ctrl_i,
  input  logic [rbst_pkg::W-1:0]  origin_i,
  input  logic [rbst_pkg::W-1:0]  dir_i,
  input  logic [rbst_pkg::W-1:0]  cmin_i,
  input  logic [rbst_pkg::W-1:0]  cmax_i,
  output logic                    done_o,
  output logic [rbst_pkg::W-1:0]  t_near_o,
  output logic [rbst_pkg::W-1:0]  t_far_o
);
  import rbst_pkg::*;

  logic [W-1:0]               origin_q;
  logic [W-1:0]               inv_q;
  logic [W-1:0]               cmin_q, cmax_q;
  logic [W-1:0]               recip;
  logic                       recip_done;
  logic signed [W:0]          diff_min, diff_max;
  logic signed [PROD_W-1:0]   prod_min_d, prod_max_d;
  logic signed [PROD_W-1:0]   prod_min_q, prod_max_q;
  logic [W-1:0]               t_min, t_max;
  logic [W-1:0]               t_near_q, t_far_q;

  function automatic logic [W-1:0] floor_sat(input logic [PROD_W-1:0] p);
    logic [SHIFT_W-1:0] s;
    s = p[PROD_W-1:FRAC];
    if ((&s[SHIFT_W-1:W-1]) || !(|s[SHIFT_W-1:W-1])) begin
      floor_sat = s[W-1:0];
    end else begin
      floor_sat = s[SHIFT_W-1] ? S32_MIN : S32_MAX;
    end
  endfunction

  rbst_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.ld),
    .d_i     (dir_i),
    .done_o  (recip_done),
    .recip_o (recip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      inv_q    <= '0;
    end else begin
      if (ctrl_i.ld) begin
        origin_q <= origin_i;
      end
      if (recip_done) begin
        inv_q <= recip;
      end
    end
  end

  // The differences stay exact at 33 bits, the products exact at 65 bits.
  assign diff_min   = $signed({cmin_q[W-1], cmin_q}) - $signed({origin_q[W-1], origin_q});
  assign diff_max   = $signed({cmax_q[W-1], cmax_q}) - $signed({origin_q[W-1], origin_q});
  assign prod_min_d = diff_min * $signed(inv_q);
  assign prod_max_d = diff_max * $signed(inv_q);

  assign t_min = floor_sat(prod_min_q);
  assign t_max = floor_sat(prod_max_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tst) begin
      cmin_q <= cmin_i;
      cmax_q <= cmax_i;
    end
    prod_min_q <= prod_min_d;
    prod_max_q <= prod_max_d;
    // A negative reciprocal flips which slab plane is entered first.
    t_near_q   <= inv_q[W-1] ? t_max : t_min;
    t_far_q    <= inv_q[W-1] ? t_min : t_max;
  end

  assign done_o   = recip_done;
  assign t_near_o = t_near_q;
  assign t_far_o  = t_far_q;

endmodule

// File: src/rbst_checker.sv
// Port-level checks for the slab test top level, attached by a bind statement.
// Depends on rbst_pkg and ray_box_slab_test_top.
module rbst_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [rbst_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [rbst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import rbst_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid_i & s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_DATA_W-1:1] == '0))
    else $error("output padding bits not zero");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready_o)
    else $error("input ready right after a beat");

  a_test_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser_i == REQ_TEST) && !m_axis_tvalid_o |-> ##4 m_axis_tvalid_o)
    else $error("box test gave no result on time");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser_i == REQ_LOAD) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("ray load produced a result");

endmodule

bind ray_box_slab_test_top rbst_props u_rbst_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
